/* rtl/dmwbc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the direct-mapped write-back cache.
// Used by the cost unit and the top level; depends on nothing.
package dmwbc_pkg;

	localparam int WORD_BYTES       = 4;
	localparam int WORD_SH          = 2;
	localparam int DEF_LINE_BYTES   = 64;
	localparam int DEF_CACHE_BYTES  = 16384;
	localparam int DEF_MEMORY_BYTES = 262144;

	localparam int ADDR_W    = 18;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 2;
	localparam int COST_W    = 10;
	localparam int ACOST_W   = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MEM_READ    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_READ  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_WRITE = 2'd3;

	localparam logic [COST_W-1:0] RST_MEM_READ    = 10'd100;
	localparam logic [COST_W-1:0] RST_MEM_WRITE   = 10'd50;
	localparam logic [COST_W-1:0] RST_CACHE_READ  = 10'd1;
	localparam logic [COST_W-1:0] RST_CACHE_WRITE = 10'd1;

	// What happened to one transaction, handed to the cost unit.
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
		logic miss;
		logic wb;
	} dmwbc_ev_t;

endpackage

/* rtl/direct_mapped_writeback_cache.sv */
`timescale 1ns / 1ps
// Top level of the direct-mapped write-back write-allocate cache with its backing memory.
// Depends on dmwbc_pkg and dmwbc_cost.

// After reset the block sweeps the backing memory and the tag memory to zero, one word
// per cycle; no transaction is taken until the sweep ends, while configuration writes
// are taken throughout. Tags, cache lines and backing memory sit in three single-port
// memories with registered reads. A miss moves the line one word per cycle through the
// single memory ports: a clean miss fills the line from memory, a miss with a dirty
// victim first writes the victim back and then fills; a line holds 16 words by default.
// A finished result waits in the output register while the block may already take the
// next transaction.
module direct_mapped_writeback_cache import dmwbc_pkg::*; #(
	parameter int LINE_BYTES   = DEF_LINE_BYTES,
	parameter int CACHE_BYTES  = DEF_CACHE_BYTES,
	parameter int MEMORY_BYTES = DEF_MEMORY_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COST_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [ADDR_W-1:0]    address,
	input  logic [DATA_W-1:0]    write_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DATA_W-1:0]    read_data,
	output logic                 hit,
	output logic                 wrote_back,
	output logic [ACOST_W-1:0]   access_cost,
	output logic [DATA_W-1:0]    total_time
);

	localparam int LINE_WORDS = LINE_BYTES / WORD_BYTES;
	localparam int NUM_LINES  = CACHE_BYTES / LINE_BYTES;
	localparam int OFF_W      = $clog2(LINE_WORDS);
	localparam int IDX_LOG    = $clog2(NUM_LINES);
	localparam int IDX_W      = (IDX_LOG > 0) ? IDX_LOG : 1;
	localparam int MEM_LOG    = $clog2(MEMORY_BYTES / WORD_BYTES);
	localparam int AWORD_W    = ADDR_W - WORD_SH;
	localparam int WA         = (MEM_LOG < AWORD_W) ? MEM_LOG : AWORD_W;
	localparam int TAG_LOG    = WA - OFF_W - IDX_LOG;
	localparam int TAG_W      = (TAG_LOG > 0) ? TAG_LOG : 1;
	localparam int CA         = OFF_W + IDX_LOG;
	localparam int TE_W       = TAG_W + 2;
	localparam int BEAT_W     = OFF_W + 1;

	localparam logic [IDX_W-1:0]  IDX_MASK  = IDX_W'(NUM_LINES - 1);
	localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(LINE_WORDS);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOOKUP = 3'd2;
	localparam logic [2:0] ST_WBACK  = 3'd3;
	localparam logic [2:0] ST_FILL   = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic [WA-1:0]     clr_q;
	logic [BEAT_W-1:0] beat_q;
	logic              out_valid_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [WA-1:0]     wa_q;
	logic [DATA_W-1:0] wdata_q;
	logic [TAG_W-1:0]  old_tag_q;
	logic              hit_q;
	logic              wb_q;
	logic [DATA_W-1:0] rdata_q;

	logic [DATA_W-1:0]  read_data_q;
	logic               hit_out_q;
	logic               wb_out_q;
	logic [ACOST_W-1:0] cost_out_q;
	logic [DATA_W-1:0]  total_out_q;

	// Memories and their single ports.
	logic [TE_W-1:0]   tag_mem [0:(2**IDX_W)-1];
	logic [DATA_W-1:0] line_mem [0:(2**CA)-1];
	logic [DATA_W-1:0] main_mem [0:(2**WA)-1];

	logic              t_en, t_we;
	logic [IDX_W-1:0]  t_addr;
	logic [TE_W-1:0]   t_wd, t_rd;
	logic              d_en, d_we;
	logic [CA-1:0]     d_addr;
	logic [DATA_W-1:0] d_wd, d_rd;
	logic              m_en, m_we;
	logic [WA-1:0]     m_addr;
	logic [DATA_W-1:0] m_wd, m_rd;

	logic              in_acc;
	logic              is_access;
	logic              out_load;
	logic [WA-1:0]     in_wa, in_idx_sh, cur_idx_sh, cur_tag_sh;
	logic [IDX_W-1:0]  in_idx, cur_idx;
	logic [TAG_W-1:0]  cur_tag;
	logic [WA-1:0]     old_base, new_base;
	logic [CA-1:0]     line_base;
	logic [BEAT_W-1:0] beat_m1;
	logic [OFF_W-1:0]  beat_off, prev_off, word_off;
	logic              lk_valid, lk_dirty, lk_hit;
	dmwbc_ev_t         ev;
	logic [ACOST_W-1:0] cost;
	logic [DATA_W-1:0]  total_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign is_access = (cmd_q == CMD_READ) || (cmd_q == CMD_WRITE);

	always_comb begin
		in_wa      = address[WA+WORD_SH-1:WORD_SH];
		in_idx_sh  = in_wa >> OFF_W;
		in_idx     = in_idx_sh[IDX_W-1:0] & IDX_MASK;
		cur_idx_sh = wa_q >> OFF_W;
		cur_idx    = cur_idx_sh[IDX_W-1:0] & IDX_MASK;
		cur_tag_sh = wa_q >> (OFF_W + IDX_LOG);
		cur_tag    = cur_tag_sh[TAG_W-1:0];
		word_off   = wa_q[OFF_W-1:0];
		old_base   = (WA'(old_tag_q) << (OFF_W + IDX_LOG)) | (WA'(cur_idx) << OFF_W);
		new_base   = wa_q & ~WA'(LINE_WORDS - 1);
		line_base  = wa_q[CA-1:0] & ~CA'(LINE_WORDS - 1);
		beat_m1    = beat_q - 1'b1;
		beat_off   = beat_q[OFF_W-1:0];
		prev_off   = beat_m1[OFF_W-1:0];
		lk_valid   = t_rd[TE_W-1];
		lk_dirty   = t_rd[TE_W-2];
		lk_hit     = lk_valid && (t_rd[TAG_W-1:0] == cur_tag);
	end

	// Port control of the three memories.
	always_comb begin
		t_en = 1'b0; t_we = 1'b0; t_addr = cur_idx; t_wd = '0;
		d_en = 1'b0; d_we = 1'b0; d_addr = wa_q[CA-1:0]; d_wd = wdata_q;
		m_en = 1'b0; m_we = 1'b0; m_addr = new_base; m_wd = d_rd;
		case (state_q)
			ST_CLEAR: begin
				m_we   = 1'b1;
				m_addr = clr_q;
				m_wd   = '0;
				t_we   = 1'b1;
				t_addr = clr_q[IDX_W-1:0];
			end
			ST_IDLE: begin
				if (in_acc && (cmd inside {CMD_READ, CMD_WRITE})) begin
					t_en   = 1'b1;
					t_addr = in_idx;
					d_en   = 1'b1;
					d_addr = in_wa[CA-1:0];
				end
			end
			ST_LOOKUP: begin
				if (lk_hit && (cmd_q == CMD_WRITE)) begin
					d_we = 1'b1;
					t_we = 1'b1;
					t_wd = {1'b1, 1'b1, cur_tag};
				end
			end
			ST_WBACK: begin
				// Read one victim word per cycle, write the previous one to memory.
				if (beat_q != BEAT_LAST) begin
					d_en   = 1'b1;
					d_addr = line_base | CA'(beat_off);
				end
				if (beat_q != '0) begin
					m_we   = 1'b1;
					m_addr = old_base | WA'(prev_off);
				end
			end
			ST_FILL: begin
				if (beat_q != BEAT_LAST) begin
					m_en   = 1'b1;
					m_addr = new_base | WA'(beat_off);
				end
				if (beat_q != '0) begin
					d_we   = 1'b1;
					d_addr = line_base | CA'(prev_off);
					d_wd   = ((prev_off == word_off) && (cmd_q == CMD_WRITE)) ? wdata_q : m_rd;
				end
				if (beat_q == BEAT_LAST) begin
					t_we = 1'b1;
					t_wd = {1'b1, (cmd_q == CMD_WRITE), cur_tag};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (t_we) tag_mem[t_addr] <= t_wd;
		if (t_en) t_rd <= tag_mem[t_addr];
	end

	always_ff @(posedge clk) begin
		if (d_we) line_mem[d_addr] <= d_wd;
		if (d_en) d_rd <= line_mem[d_addr];
	end

	always_ff @(posedge clk) begin
		if (m_we) main_mem[m_addr] <= m_wd;
		if (m_en) m_rd <= main_mem[m_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) state_q <= (cmd inside {CMD_READ, CMD_WRITE}) ? ST_LOOKUP : ST_DONE;
				end
				ST_LOOKUP: begin
					beat_q <= '0;
					if (lk_hit)                    state_q <= ST_DONE;
					else if (lk_valid && lk_dirty) state_q <= ST_WBACK;
					else                           state_q <= ST_FILL;
				end
				ST_WBACK: begin
					if (beat_q == BEAT_LAST) begin
						beat_q  <= '0;
						state_q <= ST_FILL;
					end else begin
						beat_q <= beat_q + 1'b1;
					end
				end
				ST_FILL: begin
					if (beat_q == BEAT_LAST) state_q <= ST_DONE;
					else                     beat_q  <= beat_q + 1'b1;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ev.rd   = (cmd_q == CMD_READ);
		ev.wr   = (cmd_q == CMD_WRITE);
		ev.clr  = (cmd_q == CMD_CLEAR);
		ev.miss = is_access && !hit_q;
		ev.wb   = is_access && wb_q;
	end

	dmwbc_cost u_cost (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ev           (ev),
		.commit       (out_load),
		.cost         (cost),
		.total_next   (total_next)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= cmd;
			wa_q    <= in_wa;
			wdata_q <= write_data;
		end
		if (state_q == ST_LOOKUP) begin
			hit_q     <= lk_hit;
			wb_q      <= !lk_hit && lk_valid && lk_dirty;
			old_tag_q <= t_rd[TAG_W-1:0];
			if (lk_hit) rdata_q <= d_rd;
		end
		// The requested word passes by during the fill.
		if ((state_q == ST_FILL) && (beat_q != '0) && (prev_off == word_off)) rdata_q <= m_rd;
		if (out_load) begin
			read_data_q <= ev.rd ? rdata_q : '0;
			hit_out_q   <= is_access && hit_q;
			wb_out_q    <= ev.wb;
			cost_out_q  <= cost;
			total_out_q <= total_next;
		end
	end

	assign read_data   = read_data_q;
	assign hit         = hit_out_q;
	assign wrote_back  = wb_out_q;
	assign access_cost = cost_out_q;
	assign total_time  = total_out_q;

	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && wrote_back))
		else $error("hit and write-back reported for the same transaction");

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WBACK || state_q == ST_FILL) |-> (beat_q <= BEAT_LAST))
		else $error("line transfer counter ran past the line");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared one cycle after acceptance");

endmodule

/* rtl/dmwbc_cost.sv */
`timescale 1ns / 1ps
// Cost registers, per-transaction cost and the running time total.
// Depends on dmwbc_pkg.
module dmwbc_cost import dmwbc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COST_W-1:0]    cfg_data,
	input  dmwbc_ev_t            ev,
	input  logic                 commit,
	output logic [ACOST_W-1:0]   cost,
	output logic [DATA_W-1:0]    total_next
);

	logic [COST_W-1:0] mem_read_q;
	logic [COST_W-1:0] mem_write_q;
	logic [COST_W-1:0] cache_read_q;
	logic [COST_W-1:0] cache_write_q;
	logic [DATA_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_read_q    <= RST_MEM_READ;
			mem_write_q   <= RST_MEM_WRITE;
			cache_read_q  <= RST_CACHE_READ;
			cache_write_q <= RST_CACHE_WRITE;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_MEM_READ:    mem_read_q    <= cfg_data;
				CFG_MEM_WRITE:   mem_write_q   <= cfg_data;
				CFG_CACHE_READ:  cache_read_q  <= cfg_data;
				CFG_CACHE_WRITE: cache_write_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cost = '0;
		if (ev.miss) cost = cost + ACOST_W'(mem_read_q);
		if (ev.wb)   cost = cost + ACOST_W'(mem_write_q);
		if (ev.rd)   cost = cost + ACOST_W'(cache_read_q);
		if (ev.wr)   cost = cost + ACOST_W'(cache_write_q);
		total_next = ev.clr ? '0 : total_q + DATA_W'(cost);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (commit) begin
			total_q <= total_next;
		end
	end

endmodule
